[rtl/core/tmkps_pkg.sv]
// shared types and constants of the tick scheduler
package tmkps_pkg;

	localparam int ENTRIES   = 64;
	localparam int TIME_BITS = 16;
	localparam int SLOT_W    = $clog2(ENTRIES);
	localparam int PID_W     = 7;
	localparam int BURST_W   = 8;
	localparam int PRIO_W    = 8;
	localparam int KEY_W     = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// operation codes of an input word
	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_SELECT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREEMPTIVE = 1'b1;

	// busy count saturates here: only zero, one or more matter
	localparam logic [1:0] BUSY_SAT = 2'd2;

	typedef struct packed {
		logic [1:0]           func;
		logic [5:0]           entry_slot;
		logic [TIME_BITS-1:0] arrival_tick;
		logic [BURST_W-1:0]   burst_length;
		logic [PRIO_W-1:0]    priority_level;
	} in_word_t;

	typedef struct packed {
		logic [PID_W-1:0]     running_pid;
		logic                 completed;
		logic [TIME_BITS-1:0] finish_tick;
		logic [TIME_BITS-1:0] turnaround;
		logic [TIME_BITS-1:0] waiting;
		logic                 all_done;
	} out_word_t;

	// selection token handed from cell to cell
	typedef struct packed {
		logic                 live;
		logic                 found;
		logic                 forced;
		logic [SLOT_W-1:0]    slot;
		logic [KEY_W-1:0]     key;
		logic [BURST_W-1:0]   rem;
		logic [TIME_BITS-1:0] arrival;
		logic [BURST_W-1:0]   burst;
		logic [1:0]           busy_cnt;
	} tok_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic                 clr;
		logic                 ld;
		logic [5:0]           ld_slot;
		logic [TIME_BITS-1:0] ld_arrival;
		logic [BURST_W-1:0]   ld_burst;
		logic [PRIO_W-1:0]    ld_prio;
		logic                 dec;
		logic [SLOT_W-1:0]    dec_slot;
		logic                 key_select;
		logic                 hold_en;
		logic [SLOT_W-1:0]    hold_slot;
		logic [TIME_BITS-1:0] now_tick;
	} ctrl_t;

endpackage

[rtl/core/tmkps_cell.sv]
// one table slot of the scheduler with its stage of the selection chain
module tmkps_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tmkps_pkg::SLOT_W-1:0] idx,
	input  tmkps_pkg::ctrl_t            ctrl,
	input  tmkps_pkg::tok_t             tok_in,
	output tmkps_pkg::tok_t             tok_out
);

	logic                                valid_q;
	logic [tmkps_pkg::TIME_BITS-1:0]     arrival_q;
	logic [tmkps_pkg::BURST_W-1:0]       burst_q;
	logic [tmkps_pkg::BURST_W-1:0]       rem_q;
	logic [tmkps_pkg::PRIO_W-1:0]        prio_q;
	tmkps_pkg::tok_t                     tok_q;
	tmkps_pkg::tok_t                     tok_nxt;
	logic                                busy;
	logic                                rdy;
	logic [tmkps_pkg::KEY_W-1:0]         key;
	logic                                hold_hit;
	logic                                ld_hit;
	logic                                dec_hit;

	// slot status seen by the selection
	assign busy     = valid_q && (rem_q != '0);
	assign rdy      = busy && (arrival_q <= ctrl.now_tick);
	assign key      = ctrl.key_select ? prio_q : rem_q;
	assign hold_hit = ctrl.hold_en && (ctrl.hold_slot == idx);
	assign ld_hit   = ctrl.ld && (ctrl.ld_slot == 6'(idx));
	assign dec_hit  = ctrl.dec && (ctrl.dec_slot == idx);

	// compare own entry against the token, held entry overrides
	always_comb begin
		tok_nxt = tok_in;
		if (busy && tok_in.busy_cnt != tmkps_pkg::BUSY_SAT) begin
			tok_nxt.busy_cnt = tok_in.busy_cnt + 2'd1;
		end
		if (tok_in.live && rdy && !tok_in.forced) begin
			if (hold_hit || !tok_in.found || key < tok_in.key) begin
				tok_nxt.found   = 1'b1;
				tok_nxt.forced  = hold_hit;
				tok_nxt.slot    = idx;
				tok_nxt.key     = key;
				tok_nxt.rem     = rem_q;
				tok_nxt.arrival = arrival_q;
				tok_nxt.burst   = burst_q;
			end
		end
	end

	// token stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

	// slot valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (ld_hit) begin
			valid_q <= 1'b1;
		end
	end

	// slot contents, written on load, remaining work counted down on run
	always_ff @(posedge clk) begin
		if (ld_hit) begin
			arrival_q <= ctrl.ld_arrival;
			burst_q   <= ctrl.ld_burst;
			rem_q     <= ctrl.ld_burst;
			prio_q    <= ctrl.ld_prio;
		end else if (dec_hit) begin
			rem_q <= rem_q - {{(tmkps_pkg::BURST_W-1){1'b0}}, 1'b1};
		end
	end

endmodule

[rtl/core/tick_min_key_process_scheduler_unit.sv]
// top level of the tick-driven shortest-key process scheduler
//
// input channel (item_valid / item_ready / item) takes one word per handshake:
//   clear wipes the table, time and hold; load writes one slot; tick runs one
//   time step. clear and load finish in the cycle they are taken and give no
//   result word. an unused operation code is taken and dropped.
// a tick sends a selection token down a chain of one cell per slot, one cell
//   a cycle, then latches the winner in best_q and, in the emit state,
//   updates the slot and writes the result word; the emit state waits while
//   the output register is still full and not taken.
// ticks therefore run one at a time; clear and load words are taken every cycle
//   while no tick is in flight.
// output channel (result_valid / result_ready / result) carries one word per
//   tick from an output register. a stalled receiver holds back the update
//   step of the next tick, and no input word is taken until that step is done.
// configuration: cfg_we, cfg_index, cfg_data write key_select or preemptive;
//   the user must write them only while no tick is in flight; not enforced.
// reset: table empty, time zero, no hold, key_select 0, preemptive 1.
module tick_min_key_process_scheduler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  tmkps_pkg::in_word_t             item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output tmkps_pkg::out_word_t            result,
	input  logic                            cfg_we,
	input  logic [tmkps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                            cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                              state_q;
	logic                                key_select_q;
	logic                                preemptive_q;
	logic [tmkps_pkg::TIME_BITS-1:0]     now_q;
	logic                                held_q;
	logic [tmkps_pkg::SLOT_W-1:0]        running_slot_q;
	tmkps_pkg::tok_t                     best_q;
	logic                                result_valid_q;
	tmkps_pkg::out_word_t                result_q;

	tmkps_pkg::ctrl_t                    ctrl;
	tmkps_pkg::tok_t                     head_tok;
	tmkps_pkg::tok_t                     chain_tok [tmkps_pkg::ENTRIES];
	logic                                item_fire;
	logic                                tick_fire;
	logic                                emit_fire;
	logic [tmkps_pkg::TIME_BITS-1:0]     now_next;
	logic [tmkps_pkg::TIME_BITS-1:0]     tat;
	logic [tmkps_pkg::TIME_BITS-1:0]     burst_ext;
	logic                                done;
	tmkps_pkg::out_word_t                result_nxt;

	assign item_ready = (state_q == ST_IDLE);
	assign item_fire  = item_valid && item_ready;
	assign tick_fire  = item_fire && (item.func == tmkps_pkg::FUNC_TICK);
	assign emit_fire  = (state_q == ST_EMIT) && (!result_valid_q || result_ready);

	// broadcast control to the cells
	always_comb begin
		ctrl            = '0;
		ctrl.clr        = item_fire && (item.func == tmkps_pkg::FUNC_CLEAR);
		ctrl.ld         = item_fire && (item.func == tmkps_pkg::FUNC_LOAD);
		ctrl.ld_slot    = item.entry_slot;
		ctrl.ld_arrival = item.arrival_tick;
		ctrl.ld_burst   = item.burst_length;
		ctrl.ld_prio    = item.priority_level;
		ctrl.dec        = emit_fire && best_q.found;
		ctrl.dec_slot   = best_q.slot;
		ctrl.key_select = key_select_q;
		ctrl.hold_en    = !preemptive_q && held_q;
		ctrl.hold_slot  = running_slot_q;
		ctrl.now_tick   = now_q;
	end

	// empty token enters the first cell on a tick
	always_comb begin
		head_tok      = '0;
		head_tok.live = tick_fire;
	end

	// chain of slot cells
	for (genvar i = 0; i < tmkps_pkg::ENTRIES; i++) begin : g_cell
		if (i == 0) begin : g_head
			tmkps_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (tmkps_pkg::SLOT_W'(i)),
				.ctrl    (ctrl),
				.tok_in  (head_tok),
				.tok_out (chain_tok[i])
			);
		end else begin : g_body
			tmkps_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (tmkps_pkg::SLOT_W'(i)),
				.ctrl    (ctrl),
				.tok_in  (chain_tok[i-1]),
				.tok_out (chain_tok[i])
			);
		end
	end

	// result of the tick from the latched winner
	always_comb begin
		now_next   = (now_q == tmkps_pkg::TIME_MAX) ? now_q :
		             now_q + {{(tmkps_pkg::TIME_BITS-1){1'b0}}, 1'b1};
		done       = best_q.found && (best_q.rem == {{(tmkps_pkg::BURST_W-1){1'b0}}, 1'b1});
		tat        = now_next - best_q.arrival;
		burst_ext  = {{(tmkps_pkg::TIME_BITS-tmkps_pkg::BURST_W){1'b0}}, best_q.burst};
		result_nxt = '0;
		if (best_q.found) begin
			result_nxt.running_pid = tmkps_pkg::PID_W'(best_q.slot) +
			                         {{(tmkps_pkg::PID_W-1){1'b0}}, 1'b1};
		end
		if (done) begin
			result_nxt.completed   = 1'b1;
			result_nxt.finish_tick = now_next;
			result_nxt.turnaround  = tat;
			result_nxt.waiting     = (tat >= burst_ext) ? tat - burst_ext : '0;
		end
		result_nxt.all_done = (best_q.busy_cnt == 2'd0) ||
		                      (best_q.busy_cnt == 2'd1 && done);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (tick_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chain_tok[tmkps_pkg::ENTRIES-1].live) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// winner leaving the last cell
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && chain_tok[tmkps_pkg::ENTRIES-1].live) begin
			best_q <= chain_tok[tmkps_pkg::ENTRIES-1];
		end
	end

	// time, hold and running slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q          <= '0;
			held_q         <= 1'b0;
			running_slot_q <= '0;
		end else if (ctrl.clr) begin
			now_q          <= '0;
			held_q         <= 1'b0;
			running_slot_q <= '0;
		end else if (ctrl.ld) begin
			if (held_q && 6'(running_slot_q) == item.entry_slot) begin
				held_q <= 1'b0;
			end
		end else if (emit_fire) begin
			now_q  <= now_next;
			held_q <= best_q.found && !done;
			if (best_q.found) begin
				running_slot_q <= best_q.slot;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_select_q <= 1'b0;
			preemptive_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				tmkps_pkg::CFG_KEY_SELECT: key_select_q <= cfg_data;
				tmkps_pkg::CFG_PREEMPTIVE: preemptive_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			result_q <= result_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/core/tmkps_checker.sv]
// port-level checks of the scheduler and their binding to the top level
module tmkps_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input tmkps_pkg::in_word_t  item,
	input logic                 result_valid,
	input logic                 result_ready,
	input tmkps_pkg::out_word_t result
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// a tick keeps the input closed in the following cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.func == tmkps_pkg::FUNC_TICK |=> !item_ready)
		else $error("input taken during a tick");

	// statistics are zero unless a process finished
	a_stats_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.completed |->
		result.finish_tick == '0 && result.turnaround == '0 && result.waiting == '0)
		else $error("statistics set without completion");

	// completion needs a running process
	a_done_pid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.completed |-> result.running_pid != '0)
		else $error("completion reported while idle");

	// waiting never exceeds turnaround
	a_wait_le_tat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.completed |-> result.waiting <= result.turnaround)
		else $error("waiting above turnaround");

endmodule

bind tick_min_key_process_scheduler_unit tmkps_checker u_tmkps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
